// ===== design/nmp_pkg.sv =====
// Shared types and constants of the normalized motion profile block.
// No dependencies; nmp_minjerk, nmp_cfg and the top level import this package.
`default_nettype none
package nmp_pkg;

   // Fixed-point format of all internal values
   localparam int FRAC_BITS = 16;
   localparam int ONE       = 1 << FRAC_BITS;
   localparam int TWO_ONE   = 2 << FRAC_BITS;

   // Acceleration magnitude limit, 2^33 - 1
   localparam logic [33:0] ACC_LIM = {1'b0, {33{1'b1}}};

   // Peak speed of the minimum jerk profile, 15/8
   localparam int PEAK_MJ = (15 * ONE) >> 3;

   // Profile codes
   localparam logic [1:0] MODE_LINEAR  = 2'd0;
   localparam logic [1:0] MODE_MINJERK = 2'd1;
   localparam logic [1:0] MODE_TRAP    = 2'd2;

   // Register indexes
   localparam logic [1:0] CSR_MODE = 2'd0;
   localparam logic [1:0] CSR_FRAC = 2'd1;

   // Configuration and derived constants seen by the datapath
   typedef struct packed {
      logic        busy;
      logic [1:0]  mode;
      logic [15:0] a;
      logic [15:0] rest;
      logic [17:0] peak;
      logic [33:0] accm;
   } cfg_type;

endpackage
`default_nettype wire

// ===== design/nmp_delay.sv =====
// Payload delay line with a common advance enable.
// No dependencies.
`default_nettype none
module nmp_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [WIDTH-1:0] din,
   output logic      [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] pipe_ff [0:DEPTH-1];

   // Shift the line on every advance
   always_ff @(posedge clock) begin
      if (en) begin
         pipe_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            pipe_ff[i] <= pipe_ff[i-1];
         end
      end
   end

   assign dout = pipe_ff[DEPTH-1];

endmodule
`default_nettype wire

// ===== design/nmp_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage, MSB first.
// No dependencies. The divisor must stay stable while items are in flight.
`default_nettype none
module nmp_div_pipe #(
   parameter int NW = 32,
   parameter int DW = 16,
   parameter int QW = 16
) (
   input  wire logic          clock,
   input  wire logic          en,
   input  wire logic [NW-1:0] num,
   input  wire logic [DW-1:0] den,
   output logic      [QW-1:0] quo
);

   localparam int W = (NW > DW + QW) ? NW : DW + QW;

   logic [W-1:0]  rem_w [0:QW-1];
   logic [QW-1:0] quo_w [0:QW];

   assign rem_w[0] = W'(num);
   assign quo_w[0] = '0;

   for (genvar i = 0; i < QW; i++) begin : g_stage
      localparam int B = QW - 1 - i;
      logic [W-1:0]  sub_c;
      logic          hit_c;
      logic [QW-1:0] quo_in;
      logic [QW-1:0] quo_ff;

      // Trial subtract of the shifted divisor
      always_comb begin
         sub_c  = W'(den) << B;
         hit_c  = rem_w[i] >= sub_c;
         quo_in = quo_w[i];
         if (hit_c) begin
            quo_in[B] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            quo_ff <= quo_in;
         end
      end
      assign quo_w[i+1] = quo_ff;

      // Carry the partial remainder to the next stage
      if (i < QW - 1) begin : g_rem
         logic [W-1:0] rem_in;
         logic [W-1:0] rem_ff;
         assign rem_in = hit_c ? rem_w[i] - sub_c : rem_w[i];
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff <= rem_in;
            end
         end
         assign rem_w[i+1] = rem_ff;
      end
   end

   assign quo = quo_w[QW];

endmodule
`default_nettype wire

// ===== design/nmp_minjerk.sv =====
// Five-stage quintic minimum jerk evaluator: position, velocity, acceleration.
// Depends on nmp_pkg.
`default_nettype none
module nmp_minjerk (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [16:0] u,
   output logic      [20:0] pos,
   output logic      [18:0] vel,
   output logic      [21:0] acc_mag,
   output logic             acc_neg
);
   import nmp_pkg::*;

   // Stage 1: u^2, p = u(1-u), |1-2u|
   logic [33:0] uu_c, uw_c;
   logic [16:0] w_c;
   logic [16:0] b_in;
   logic        neg_in;
   logic [16:0] u1_ff, u2_ff, b1_ff;
   logic [14:0] pq1_ff;
   logic        neg1_ff;

   always_comb begin
      w_c  = 17'(ONE) - u;
      uu_c = 34'(u) * 34'(u);
      uw_c = 34'(u) * 34'(w_c);
      if ({1'b0, u, 1'b0} > 19'(ONE)) begin
         b_in   = 17'({u, 1'b0} - 18'(ONE));
         neg_in = 1'b1;
      end else begin
         b_in   = 17'(18'(ONE) - {u, 1'b0});
         neg_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u1_ff   <= u;
         u2_ff   <= uu_c[32:16];
         pq1_ff  <= uw_c[30:16];
         b1_ff   <= b_in;
         neg1_ff <= neg_in;
      end
   end

   // Stage 2: u^3, p^2, p(1-2u)
   logic [33:0] u3p_c;
   logic [29:0] vq_c;
   logic [31:0] aq_c;
   logic [16:0] u2s_ff, u3_ff;
   logic [13:0] vq2_ff;
   logic [15:0] aq2_ff;
   logic        neg2_ff;

   assign u3p_c = 34'(u2_ff) * 34'(u1_ff);
   assign vq_c  = 30'(pq1_ff) * 30'(pq1_ff);
   assign aq_c  = 32'(pq1_ff) * 32'(b1_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         u2s_ff  <= u1_ff;
         u3_ff   <= u3p_c[32:16];
         vq2_ff  <= vq_c[29:16];
         aq2_ff  <= aq_c[31:16];
         neg2_ff <= neg1_ff;
      end
   end

   // Stage 3: u^4
   logic [33:0] u4p_c;
   logic [16:0] u3s_ff, u33_ff, u4_ff;
   logic [13:0] vq3_ff;
   logic [15:0] aq3_ff;
   logic        neg3_ff;

   assign u4p_c = 34'(u3_ff) * 34'(u2s_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         u3s_ff  <= u2s_ff;
         u33_ff  <= u3_ff;
         u4_ff   <= u4p_c[32:16];
         vq3_ff  <= vq2_ff;
         aq3_ff  <= aq2_ff;
         neg3_ff <= neg2_ff;
      end
   end

   // Stage 4: u^5
   logic [33:0] u5p_c;
   logic [16:0] u34_ff, u44_ff, u5_ff;
   logic [13:0] vq4_ff;
   logic [15:0] aq4_ff;
   logic        neg4_ff;

   assign u5p_c = 34'(u4_ff) * 34'(u3s_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         u34_ff  <= u33_ff;
         u44_ff  <= u4_ff;
         u5_ff   <= u5p_c[32:16];
         vq4_ff  <= vq3_ff;
         aq4_ff  <= aq3_ff;
         neg4_ff <= neg3_ff;
      end
   end

   // Stage 5: combine the polynomial, clamp below at zero, scale rates
   logic [22:0] plus_c, minus_c;
   logic [20:0] pos_in;
   logic [20:0] pos_ff;
   logic [18:0] vel_ff;
   logic [21:0] acc_ff;
   logic        neg_ff;

   always_comb begin
      plus_c  = 23'(u34_ff) * 23'd10 + 23'(u5_ff) * 23'd6;
      minus_c = 23'(u44_ff) * 23'd15;
      pos_in  = (plus_c >= minus_c) ? 21'(plus_c - minus_c) : '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pos_ff <= pos_in;
         vel_ff <= 19'(vq4_ff) * 19'd30;
         acc_ff <= 22'(aq4_ff) * 22'd60;
         neg_ff <= neg4_ff;
      end
   end

   assign pos     = pos_ff;
   assign vel     = vel_ff;
   assign acc_mag = acc_ff;
   assign acc_neg = neg_ff;

endmodule
`default_nettype wire

// ===== design/nmp_cfg.sv =====
// Configuration registers and a bit-serial divider that derives the trapezoid
// peak speed and acceleration after reset and after every write. Uses nmp_pkg.
`default_nettype none
module nmp_cfg (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            csr_valid,
   output logic                 csr_ready,
   input  wire logic [1:0]      csr_index,
   input  wire logic [15:0]     csr_data,
   output nmp_pkg::cfg_type     cfg
);
   import nmp_pkg::*;

   localparam int          ITER     = 49;
   localparam logic [5:0]  CNT_LAST = 6'(ITER - 1);
   localparam logic [48:0] NUM_INIT = 49'(1) << (2 * FRAC_BITS);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_PEAK  = 2'd1;
   localparam logic [1:0] ST_RECIP = 2'd2;
   localparam logic [1:0] ST_ACCEL = 2'd3;

   logic [1:0]  mode_ff, mode_in;
   logic [15:0] frac_ff, frac_in;
   logic [1:0]  state_ff, state_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [15:0] rem_ff, rem_in;
   logic [48:0] num_ff, num_in;
   logic [48:0] quo_ff, quo_in;
   logic [17:0] peak_ff, peak_in;
   logic [33:0] accm_ff, accm_in;

   logic        csr_xfer;
   logic [15:0] a_c, rest_c, div_d;
   logic [16:0] trial_c, diff_c;
   logic        hit_c;
   logic [48:0] quo_next;

   assign csr_ready = 1'b1;
   assign csr_xfer  = csr_valid && csr_ready;

   // Clamp the fraction to one LSB .. one half
   always_comb begin
      if (frac_ff == '0) begin
         a_c = 16'd1;
      end else if (frac_ff > 16'(ONE / 2)) begin
         a_c = 16'(ONE / 2);
      end else begin
         a_c = frac_ff;
      end
      rest_c = 16'(17'(ONE) - {1'b0, a_c});
   end

   // One restoring division step per cycle
   always_comb begin
      div_d    = (state_ff == ST_RECIP) ? a_c : rest_c;
      trial_c  = {rem_ff, num_ff[48]};
      hit_c    = trial_c >= {1'b0, div_d};
      diff_c   = trial_c - {1'b0, div_d};
      quo_next = {quo_ff[47:0], hit_c};
   end

   // Sequencer over the three divisions
   always_comb begin
      mode_in  = mode_ff;
      frac_in  = frac_ff;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      num_in   = num_ff;
      quo_in   = quo_ff;
      peak_in  = peak_ff;
      accm_in  = accm_ff;
      unique case (state_ff) inside
         ST_IDLE: begin
         end
         ST_PEAK, ST_RECIP, ST_ACCEL: begin
            rem_in = hit_c ? diff_c[15:0] : trial_c[15:0];
            num_in = {num_ff[47:0], 1'b0};
            quo_in = quo_next;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == CNT_LAST) begin
               cnt_in = '0;
               rem_in = '0;
               quo_in = '0;
               if (state_ff == ST_PEAK) begin
                  peak_in  = quo_next[17:0];
                  num_in   = NUM_INIT;
                  state_in = ST_RECIP;
               end else if (state_ff == ST_RECIP) begin
                  num_in   = {quo_next[32:0], 16'b0};
                  state_in = ST_ACCEL;
               end else begin
                  accm_in  = quo_next[33:0];
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
         end
      endcase
      // A write restarts the derivation
      if (csr_xfer) begin
         if (csr_index == CSR_MODE) begin
            mode_in = csr_data[1:0];
         end else if (csr_index == CSR_FRAC) begin
            frac_in = csr_data;
         end
         state_in = ST_PEAK;
         cnt_in   = '0;
         rem_in   = '0;
         quo_in   = '0;
         num_in   = NUM_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_LINEAR;
         frac_ff  <= 16'd16384;
         state_ff <= ST_PEAK;
         cnt_ff   <= '0;
         rem_ff   <= '0;
         num_ff   <= NUM_INIT;
         quo_ff   <= '0;
      end else begin
         mode_ff  <= mode_in;
         frac_ff  <= frac_in;
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rem_ff   <= rem_in;
         num_ff   <= num_in;
         quo_ff   <= quo_in;
      end
   end

   always_ff @(posedge clock) begin
      peak_ff <= peak_in;
      accm_ff <= accm_in;
   end

   always_comb begin
      cfg.busy = state_ff != ST_IDLE;
      cfg.mode = mode_ff;
      cfg.a    = a_c;
      cfg.rest = rest_c;
      cfg.peak = peak_ff;
      cfg.accm = accm_ff;
   end

endmodule
`default_nettype wire

// ===== design/normalized_motion_profile_top.sv =====
// Top level of the normalized motion profile: clamp, trapezoid dividers,
// minimum jerk pipeline and output register. Uses nmp_pkg and all nmp_ modules.
//
//   Port group | Direction | Carries
//   req_       | in        | tdata[19:0] norm_time
//   rsp_       | out       | tdata: pos, vel, acc, peak; tuser: at_knot
//   csr_       | in        | index 0 profile_mode, 1 accel_fraction
//
// One sample is accepted per cycle unless rsp_ stalls or cfg is busy;
// it passes clamp, phase, 16- and 17-stage divider and output registers.
// After reset and after every register write the derived trapezoid constants
// are recomputed by a bit-serial divider, with req_tready low.
// A stall on rsp_ freezes the whole pipeline; nothing is dropped or repeated.
`default_nettype none
module normalized_motion_profile_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // [19:0] norm_time
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [87:0] rsp_tdata,   // [16:0] pos, [34:17] vel, [68:35] acc,
                                          // [86:69] peak_speed
   output logic             rsp_tuser,   // [0] at_knot
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);
   import nmp_pkg::*;

   localparam int LAT = 34;

   cfg_type cfg;

   nmp_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   logic          en;
   logic          req_xfer;
   logic          rsp_valid_ff;
   logic [LAT:0]  vld_ff;

   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en && !cfg.busy;
   assign req_xfer   = req_tvalid && req_tready;

   // Advance the valid line with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[LAT-1:0], req_xfer};
         rsp_valid_ff <= vld_ff[LAT];
      end
   end

   // Clamp the time to 0 .. ONE
   logic [19:0] raw_c;
   logic [16:0] u_in, u_ff;

   always_comb begin
      raw_c = req_tdata[19:0];
      if (raw_c[19]) begin
         u_in = '0;
      end else if (raw_c[18:0] > 19'(ONE)) begin
         u_in = 17'(ONE);
      end else begin
         u_in = raw_c[16:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u_ff <= u_in;
      end
   end

   // Trapezoid phase, distance from the nearest end, middle numerator
   logic        first_c, last_c;
   logic [15:0] r_c;
   logic [17:0] m_c;
   logic [31:0] r2_ff, rsh_ff;
   logic [36:0] side_ff;

   always_comb begin
      first_c = u_ff < {1'b0, cfg.a};
      last_c  = u_ff > {1'b0, cfg.rest};
      r_c     = first_c ? u_ff[15:0] : 16'(17'(ONE) - u_ff);
      m_c     = {u_ff, 1'b0} - 18'(cfg.a);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r2_ff   <= 32'(r_c) * 32'(r_c);
         rsh_ff  <= {r_c, 16'b0};
         side_ff <= {first_c, last_c, u_ff, m_c};
      end
   end

   // First division by the fraction
   logic [15:0] t_q, v1_q;
   logic [36:0] side_a;

   nmp_div_pipe #(.NW(32), .DW(16), .QW(16)) u_div_t (
      .clock (clock), .en (en), .num (r2_ff), .den (cfg.a), .quo (t_q)
   );

   nmp_div_pipe #(.NW(32), .DW(16), .QW(16)) u_div_v1 (
      .clock (clock), .en (en), .num (rsh_ff), .den (cfg.a), .quo (v1_q)
   );

   nmp_delay #(.WIDTH(37), .DEPTH(16)) u_dly_a (
      .clock (clock), .en (en), .din (side_ff), .dout (side_a)
   );

   // Second division by one minus the fraction
   logic        first_a, last_a;
   logic [16:0] u_a;
   logic [17:0] m_a, x_c;
   logic [16:0] pos_q, vel_q;
   logic [18:0] side_b;

   always_comb begin
      first_a = side_a[36];
      last_a  = side_a[35];
      u_a     = side_a[34:18];
      m_a     = side_a[17:0];
      x_c     = (first_a || last_a) ? {2'b0, t_q} : m_a;
   end

   nmp_div_pipe #(.NW(34), .DW(17), .QW(17)) u_div_pos (
      .clock (clock), .en (en), .num ({x_c, 16'b0}), .den ({cfg.rest, 1'b0}),
      .quo (pos_q)
   );

   nmp_div_pipe #(.NW(32), .DW(16), .QW(17)) u_div_vel (
      .clock (clock), .en (en), .num ({v1_q, 16'b0}), .den (cfg.rest),
      .quo (vel_q)
   );

   nmp_delay #(.WIDTH(19), .DEPTH(17)) u_dly_b (
      .clock (clock), .en (en), .din ({first_a, last_a, u_a}), .dout (side_b)
   );

   // Minimum jerk branch, aligned to the divider outputs
   logic [20:0] mj_pos;
   logic [18:0] mj_vel;
   logic [21:0] mj_acc;
   logic        mj_neg;
   logic [62:0] mj_d;

   nmp_minjerk u_minjerk (
      .clock   (clock),
      .en      (en),
      .u       (u_ff),
      .pos     (mj_pos),
      .vel     (mj_vel),
      .acc_mag (mj_acc),
      .acc_neg (mj_neg)
   );

   nmp_delay #(.WIDTH(63), .DEPTH(LAT - 5)) u_dly_mj (
      .clock (clock), .en (en), .din ({mj_pos, mj_vel, mj_acc, mj_neg}), .dout (mj_d)
   );

   // Select the profile and saturate
   logic        first_b, last_b;
   logic [16:0] u_b;
   logic [20:0] pos_c;
   logic [18:0] vel_c;
   logic [33:0] mag_c, mag_s;
   logic [17:0] peak_c;
   logic        neg_c, knot_c;
   logic [16:0] pos_in, pos_ff;
   logic [17:0] vel_in, vel_ff, peak_in, peak_ff;
   logic [33:0] acc_in, acc_ff;
   logic        knot_ff;

   always_comb begin
      first_b = side_b[18];
      last_b  = side_b[17];
      u_b     = side_b[16:0];
      pos_c   = 21'(u_b);
      vel_c   = 19'(ONE);
      mag_c   = '0;
      neg_c   = 1'b0;
      peak_c  = 18'(ONE);
      knot_c  = (u_b == '0) || (u_b == 17'(ONE));
      case (cfg.mode)
         MODE_MINJERK: begin
            pos_c  = mj_d[62:42];
            vel_c  = mj_d[41:23];
            mag_c  = 34'(mj_d[22:1]);
            neg_c  = mj_d[0];
            knot_c = 1'b0;
            peak_c = 18'(PEAK_MJ);
         end
         MODE_TRAP: begin
            peak_c = cfg.peak;
            if (first_b) begin
               pos_c  = 21'(pos_q);
               vel_c  = 19'(vel_q);
               mag_c  = cfg.accm;
               knot_c = u_b == '0;
            end else if (last_b) begin
               pos_c  = (pos_q > 17'(ONE)) ? '0 : 21'(17'(ONE) - pos_q);
               vel_c  = 19'(vel_q);
               mag_c  = cfg.accm;
               neg_c  = 1'b1;
               knot_c = u_b == 17'(ONE);
            end else begin
               pos_c  = 21'(pos_q);
               vel_c  = 19'(cfg.peak);
               knot_c = (u_b == {1'b0, cfg.a}) || (u_b == {1'b0, cfg.rest});
            end
         end
         default: begin
         end
      endcase
      pos_in  = (pos_c > 21'(ONE)) ? 17'(ONE) : pos_c[16:0];
      vel_in  = (vel_c > 19'(TWO_ONE)) ? 18'(TWO_ONE) : vel_c[17:0];
      peak_in = (peak_c > 18'(TWO_ONE)) ? 18'(TWO_ONE) : peak_c;
      mag_s   = (mag_c > ACC_LIM) ? ACC_LIM : mag_c;
      acc_in  = (neg_c && mag_s != '0) ? 34'(-mag_s) : mag_s;
   end

   // Hold the result until transfer
   always_ff @(posedge clock) begin
      if (en) begin
         pos_ff  <= pos_in;
         vel_ff  <= vel_in;
         acc_ff  <= acc_in;
         peak_ff <= peak_in;
         knot_ff <= knot_c;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, peak_ff, acc_ff, vel_ff, pos_ff};
   assign rsp_tuser  = knot_ff;

   // No sample is taken while the constants are being derived
   a_busy_block: assert property (@(posedge clock) disable iff (reset)
      cfg.busy |-> !req_tready)
      else $error("input accepted during constant derivation");

   // Position never exceeds one
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[16:0] <= 17'(ONE))
      else $error("position out of range");

   // Minimum jerk profile has no knots
   a_mj_knot: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && cfg.mode == MODE_MINJERK) |-> !rsp_tuser)
      else $error("knot flagged in minimum jerk mode");

   // A stall freezes the valid line
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline moved during a stall");

endmodule
`default_nettype wire
